>>> src/fpsd_pkg.sv
// Package for the five-point stencil derivative block.
// Holds the shared widths, constants and the job and queue status types.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package fpsd_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int INV_W            = 24;
    localparam int DERIV_W          = 32;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;

    localparam logic [INV_W-1:0] INV_STEP_RESET = 24'd65536;
    localparam logic             REG_INV_STEP   = 1'b0;

    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_JOBS    = 3;

    // Quotient width after the fixed-point shift, clamped so that any
    // value at the top still saturates.
    localparam int QUOT_W      = 33;
    localparam int SHIFT_DIV2  = 17;
    localparam int SHIFT_DIV12 = 18;
    localparam int RECIP_SHIFT = 34;
    localparam int RECIP_LO_W  = 16;
    localparam int RECIP_HI_W  = 17;
    localparam logic [RECIP_LO_W-1:0] RECIP3_LO = 16'h5556;
    localparam logic [RECIP_HI_W-1:0] RECIP3_HI = 17'h15555;

    localparam logic [DERIV_W-1:0] DERIV_MAX = 32'h7FFF_FFFF;
    localparam logic [DERIV_W-1:0] DERIV_MIN = 32'h8000_0000;

    typedef struct packed {
        logic last;
        logic div12;
    } job_ctrl_t;

    typedef struct packed {
        logic [QLEVEL_W-1:0] level;
        logic                not_empty;
        logic                room;
    } queue_status_t;

endpackage

`default_nettype wire

>>> src/fpsd_front.sv
// Front end: holds the sample window and the mesh position count, and turns
// each accepted word into up to three derivative jobs for the queue.
// Depends on fpsd_pkg.
`default_nettype none

module fpsd_front #(
    parameter int SAMPLE_WIDTH = fpsd_pkg::SAMPLE_WIDTH_DEF,
    parameter int DW           = SAMPLE_WIDTH + 5
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    input  wire                             in_ready,
    input  wire  [SAMPLE_WIDTH-1:0]         sample,
    input  wire                             last_in,
    output logic [1:0]                      push_n,
    output logic [fpsd_pkg::MAX_JOBS-1:0][DW-1:0] job_diff,
    output fpsd_pkg::job_ctrl_t [fpsd_pkg::MAX_JOBS-1:0] job_ctrl
);

    localparam logic [2:0] COUNT_FULL = 3'd4;

    logic signed [SAMPLE_WIDTH-1:0] w0_reg, w1_reg, w2_reg, w3_reg;
    logic [2:0]                     count_reg;
    logic [2:0]                     count_next;
    logic                           accept;
    logic signed [DW-1:0]           cur_e, w0_e, w1_e, w2_e, w3_e;
    logic signed [DW-1:0]           stencil, cd_old, cd_new;

    assign accept = in_valid & in_ready;

    assign cur_e = DW'($signed(sample));
    assign w0_e  = DW'(w0_reg);
    assign w1_e  = DW'(w1_reg);
    assign w2_e  = DW'(w2_reg);
    assign w3_e  = DW'(w3_reg);

    assign stencil = w3_e - (w2_e <<< 3) + (w0_e <<< 3) - cur_e;
    assign cd_old  = w0_e - w2_e;
    assign cd_new  = cur_e - w1_e;

    assign count_next = (count_reg < COUNT_FULL) ? count_reg + 3'd1 : count_reg;

    always_comb
    begin
        push_n   = 2'd0;
        job_diff = '0;
        job_ctrl = '0;
        if (accept)
        begin
            if (!last_in)
            begin
                case (count_reg)
                    3'd0, 3'd1:
                    begin
                        push_n = 2'd0;
                    end
                    3'd2:
                    begin
                        push_n = 2'd1;
                    end
                    3'd3:
                    begin
                        push_n      = 2'd1;
                        job_diff[0] = cd_old;
                    end
                    default:
                    begin
                        push_n            = 2'd1;
                        job_diff[0]       = stencil;
                        job_ctrl[0].div12 = 1'b1;
                    end
                endcase
            end
            else
            begin
                case (count_reg)
                    3'd0:
                    begin
                        push_n           = 2'd1;
                        job_ctrl[0].last = 1'b1;
                    end
                    3'd1:
                    begin
                        push_n           = 2'd2;
                        job_ctrl[1].last = 1'b1;
                    end
                    3'd2:
                    begin
                        push_n           = 2'd3;
                        job_diff[1]      = cd_new;
                        job_ctrl[2].last = 1'b1;
                    end
                    3'd3:
                    begin
                        push_n           = 2'd3;
                        job_diff[0]      = cd_old;
                        job_diff[1]      = cd_new;
                        job_ctrl[2].last = 1'b1;
                    end
                    default:
                    begin
                        push_n            = 2'd3;
                        job_diff[0]       = stencil;
                        job_ctrl[0].div12 = 1'b1;
                        job_diff[1]       = cd_new;
                        job_ctrl[2].last  = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            w0_reg    <= '0;
            w1_reg    <= '0;
            w2_reg    <= '0;
            w3_reg    <= '0;
        end
        else if (accept)
        begin
            if (last_in)
            begin
                count_reg <= '0;
                w0_reg    <= '0;
                w1_reg    <= '0;
                w2_reg    <= '0;
                w3_reg    <= '0;
            end
            else
            begin
                count_reg <= count_next;
                w0_reg    <= $signed(sample);
                w1_reg    <= w0_reg;
                w2_reg    <= w1_reg;
                w3_reg    <= w2_reg;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/fpsd_queue.sv
// Job queue between the front end and the arithmetic back end.
// Takes up to three jobs a cycle and hands out one. Depends on fpsd_pkg.
`default_nettype none

module fpsd_queue #(
    parameter int DW = fpsd_pkg::SAMPLE_WIDTH_DEF + 5
) (
    input  wire                                        clk,
    input  wire                                        rst_n,
    input  wire  [1:0]                                 push_n,
    input  wire  [fpsd_pkg::MAX_JOBS-1:0][DW-1:0]      job_diff,
    input  wire fpsd_pkg::job_ctrl_t [fpsd_pkg::MAX_JOBS-1:0] job_ctrl,
    input  wire                                        pop,
    output logic [DW-1:0]                              head_diff,
    output fpsd_pkg::job_ctrl_t                        head_ctrl,
    output fpsd_pkg::queue_status_t                    status
);

    localparam int DEPTH = fpsd_pkg::QUEUE_DEPTH;
    localparam int PW    = fpsd_pkg::QPTR_W;
    localparam int LW    = fpsd_pkg::QLEVEL_W;

    logic [DW-1:0]       mem_diff [DEPTH];
    fpsd_pkg::job_ctrl_t mem_ctrl [DEPTH];
    logic [PW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [LW-1:0]       level_reg;
    logic [LW-1:0]       level_next;
    logic                do_pop;

    assign do_pop     = pop & (level_reg != '0);
    assign level_next = level_reg + LW'(push_n) - LW'(do_pop);

    assign head_diff        = mem_diff[rd_ptr_reg];
    assign head_ctrl        = mem_ctrl[rd_ptr_reg];
    assign status.level     = level_reg;
    assign status.not_empty = (level_reg != '0);
    assign status.room      = (level_reg <= LW'(DEPTH - fpsd_pkg::MAX_JOBS));

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < fpsd_pkg::MAX_JOBS; k++)
        begin
            if (k < int'(push_n))
            begin
                mem_diff[wr_ptr_reg + PW'(k)] <= job_diff[k];
                mem_ctrl[wr_ptr_reg + PW'(k)] <= job_ctrl[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PW'(push_n);
            rd_ptr_reg <= rd_ptr_reg + PW'(do_pop);
            level_reg  <= level_next;
        end
    end

endmodule

`default_nettype wire

>>> src/fpsd_back.sv
// Arithmetic back end: scales each stencil difference by inv_step, divides
// by 2 or 12 in Q16 with truncation toward zero and saturates to 32 bits.
// Five register stages, the last being the output register. Depends on fpsd_pkg.
`default_nettype none

module fpsd_back #(
    parameter int SAMPLE_WIDTH = fpsd_pkg::SAMPLE_WIDTH_DEF,
    parameter int DW           = SAMPLE_WIDTH + 5
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire  [fpsd_pkg::INV_W-1:0]       inv_step,
    input  wire  [DW-1:0]                    head_diff,
    input  wire fpsd_pkg::job_ctrl_t         head_ctrl,
    input  wire                              head_valid,
    output logic                             pop,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [fpsd_pkg::DERIV_W-1:0]     derivative,
    output logic                             last_out
);

    localparam int NW    = DW + fpsd_pkg::INV_W + 1;
    localparam int EW    = (NW > 51) ? NW : 51;
    localparam int QW    = fpsd_pkg::QUOT_W;
    localparam int PLO_W = QW + fpsd_pkg::RECIP_LO_W;
    localparam int PHI_W = QW + fpsd_pkg::RECIP_HI_W;
    localparam int SUM_W = PHI_W + fpsd_pkg::RECIP_LO_W;

    logic                 en;
    logic                 v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    fpsd_pkg::job_ctrl_t  c1_reg, c2_reg, c3_reg;
    logic                 neg2_reg, neg3_reg, neg4_reg;
    logic                 last4_reg;

    logic signed [NW-1:0] num1_reg, num1_next;
    logic [NW-1:0]        mag;
    logic [EW-1:0]        mag_e, shifted;
    logic [QW-1:0]        m2_reg, m2_next;
    logic [PLO_W-1:0]     plo3_reg, plo3_next;
    logic [PHI_W-1:0]     phi3_reg, phi3_next;
    logic [SUM_W-1:0]     sum;
    logic [QW-1:0]        q4_reg, q4_next;
    logic [fpsd_pkg::DERIV_W-1:0] d5_reg, d5_next;
    logic                 last5_reg;

    assign en  = !v5_reg || out_ready;
    assign pop = en && head_valid;

    assign num1_next = $signed(head_diff) * $signed({1'b0, inv_step});

    always_comb
    begin
        mag     = num1_reg[NW-1] ? NW'(-num1_reg) : NW'(num1_reg);
        mag_e   = EW'(mag);
        shifted = c1_reg.div12 ? (mag_e >> fpsd_pkg::SHIFT_DIV12)
                               : (mag_e >> fpsd_pkg::SHIFT_DIV2);
        if (|shifted[EW-1:QW])
        begin
            m2_next = '1;
        end
        else
        begin
            m2_next = shifted[QW-1:0];
        end
    end

    always_comb
    begin
        if (c2_reg.div12)
        begin
            plo3_next = PLO_W'(m2_reg) * PLO_W'(fpsd_pkg::RECIP3_LO);
            phi3_next = PHI_W'(m2_reg) * PHI_W'(fpsd_pkg::RECIP3_HI);
        end
        else
        begin
            plo3_next = PLO_W'(m2_reg);
            phi3_next = '0;
        end
    end

    assign sum     = (SUM_W'(phi3_reg) << fpsd_pkg::RECIP_LO_W) + SUM_W'(plo3_reg);
    assign q4_next = c3_reg.div12 ? QW'(sum >> fpsd_pkg::RECIP_SHIFT) : plo3_reg[QW-1:0];

    always_comb
    begin
        if (neg4_reg)
        begin
            if (q4_reg > QW'(fpsd_pkg::DERIV_MIN))
            begin
                d5_next = fpsd_pkg::DERIV_MIN;
            end
            else
            begin
                d5_next = ~q4_reg[fpsd_pkg::DERIV_W-1:0] + 1'b1;
            end
        end
        else
        begin
            if (q4_reg > QW'(fpsd_pkg::DERIV_MAX))
            begin
                d5_next = fpsd_pkg::DERIV_MAX;
            end
            else
            begin
                d5_next = q4_reg[fpsd_pkg::DERIV_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= head_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num1_reg  <= num1_next;
            c1_reg    <= head_ctrl;
            m2_reg    <= m2_next;
            neg2_reg  <= num1_reg[NW-1];
            c2_reg    <= c1_reg;
            plo3_reg  <= plo3_next;
            phi3_reg  <= phi3_next;
            neg3_reg  <= neg2_reg;
            c3_reg    <= c2_reg;
            q4_reg    <= q4_next;
            neg4_reg  <= neg3_reg;
            last4_reg <= c3_reg.last;
            d5_reg    <= d5_next;
            last5_reg <= last4_reg;
        end
    end

    assign out_valid  = v5_reg;
    assign derivative = d5_reg;
    assign last_out   = last5_reg;

endmodule

`default_nettype wire

>>> src/five_point_stencil_derivative.sv
// Top level of the five-point stencil derivative block: configuration
// register, front end, job queue and arithmetic back end.
// Depends on fpsd_pkg, fpsd_front, fpsd_queue and fpsd_back.
//
// Samples enter on the s_ stream, one word per mesh point, with s_tlast on
// the final point of a mesh. Derivatives leave on the m_ stream two mesh
// positions behind; the last word of a mesh releases up to three results,
// the final one carrying m_tlast. With the queue empty, each result passes
// the queue and then the five back-end register stages. The block takes one
// word per cycle, and s_tready stays high as long as the receiver takes
// every result without a pause. The back end is a five-stage pipeline with
// one scaling multiply and a split reciprocal multiply, retiring one result
// per cycle. When the receiver holds off a waiting result the whole back
// end holds, the queue fills, and s_tready falls once fewer than three slots
// remain. After reset the queue and pipeline are empty, a new mesh starts
// and inv_step reads 1.0 (Q8.16). The user must write inv_step over the APB
// port at address 0 only while the block is idle; no logic enforces this.
`default_nettype none

module five_point_stencil_derivative #(
    parameter int SAMPLE_WIDTH = fpsd_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0: sample.
    input  wire  [((SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata,
    input  wire                                s_tlast,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // Fields from bit 0: derivative.
    output logic [fpsd_pkg::DERIV_W-1:0]       m_tdata,
    output logic                               m_tlast,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [fpsd_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire  [fpsd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [fpsd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int DW = SAMPLE_WIDTH + 5;

    logic [fpsd_pkg::INV_W-1:0]                         inv_step_reg;
    logic                                               cfg_sel;
    logic [1:0]                                         push_n;
    logic [fpsd_pkg::MAX_JOBS-1:0][DW-1:0]              job_diff;
    fpsd_pkg::job_ctrl_t [fpsd_pkg::MAX_JOBS-1:0]       job_ctrl;
    logic [DW-1:0]                                      head_diff;
    fpsd_pkg::job_ctrl_t                                head_ctrl;
    fpsd_pkg::queue_status_t                            q_status;
    logic                                               pop;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[fpsd_pkg::APB_ADDR_W-1:2] == fpsd_pkg::REG_INV_STEP);
    assign prdata  = cfg_sel ? fpsd_pkg::APB_DATA_W'(inv_step_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_step_reg <= fpsd_pkg::INV_STEP_RESET;
        end
        else if (psel && penable && pwrite && pready && cfg_sel)
        begin
            inv_step_reg <= pwdata[fpsd_pkg::INV_W-1:0];
        end
    end

    assign s_tready = q_status.room;

    fpsd_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .DW           (DW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sample   (s_tdata[SAMPLE_WIDTH-1:0]),
        .last_in  (s_tlast),
        .push_n   (push_n),
        .job_diff (job_diff),
        .job_ctrl (job_ctrl)
    );

    fpsd_queue #(
        .DW (DW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .job_diff  (job_diff),
        .job_ctrl  (job_ctrl),
        .pop       (pop),
        .head_diff (head_diff),
        .head_ctrl (head_ctrl),
        .status    (q_status)
    );

    fpsd_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .DW           (DW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .inv_step   (inv_step_reg),
        .head_diff  (head_diff),
        .head_ctrl  (head_ctrl),
        .head_valid (q_status.not_empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .derivative (m_tdata),
        .last_out   (m_tlast)
    );

`ifndef SYNTH
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.level <= fpsd_pkg::QLEVEL_W'(fpsd_pkg::QUEUE_DEPTH))
        else $error("Job queue holds more words than its depth.");

    a_last_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> q_status.not_empty)
        else $error("Last word of a mesh left no job in the queue.");

    a_drain_rate: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (q_status.level + 1'b1 >= $past(q_status.level)))
        else $error("Job queue lost more than one word in a cycle.");
`endif

endmodule

`default_nettype wire
